// File: rtl/ihf_pkg.sv
// Shared types and constants, including the checksum-adder control types, for the IPv4 header fragmenter.
package ihf_pkg;

	localparam int MAX_FRAGS        = 32;
	localparam int FRAG_UNITS_W     = 13;
	localparam logic [FRAG_UNITS_W-1:0] FRAG_UNITS_RESET = 13'd64;
	localparam int LIMIT_MULT       = MAX_FRAGS * 8;
	localparam int LIMIT_W          = FRAG_UNITS_W + $clog2(LIMIT_MULT + 1);
	localparam int MF_BIT           = 13;
	localparam int BASE_WORDS       = 7;
	localparam int CNT_W            = $clog2(BASE_WORDS);

	typedef struct packed {
		logic [7:0]  ver_ihl;
		logic [7:0]  tos;
		logic [15:0] total_len;
		logic [15:0] ident;
		logic [7:0]  ttl;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} hdr_t;

	typedef struct packed {
		logic [7:0]  frag_ver_ihl;
		logic [7:0]  frag_tos;
		logic [15:0] frag_len;
		logic [15:0] frag_ident;
		logic [15:0] flags_offset;
		logic [7:0]  frag_ttl;
		logic [7:0]  frag_protocol;
		logic [15:0] header_checksum;
		logic [31:0] frag_src;
		logic [31:0] frag_dst;
		logic        last;
		logic        too_many;
	} frag_t;

	typedef enum logic [2:0] {
		CS_HOLD,
		CS_CLEAR,
		CS_BASE,
		CS_FROM_BASE,
		CS_ACC
	} csum_op_t;

	typedef struct packed {
		csum_op_t    op;
		logic [15:0] word;
	} csum_ctrl_t;

endpackage

// File: rtl/ipv4_header_fragmenter_unit.sv
// Top level of the IPv4 header fragmenter: sequencer, config register and result register.
//
// Usage:
//  - Load frag_units (fragment length in 8-byte units) through cfg_wr_en/cfg_wr_data
//    while busy is low; it resets to 64.
//  - Present a header on in_hdr with start high; it is taken at an edge where busy is low.
//  - One fragment header per transfer appears on result, marked by done for one cycle.
//    The final one has result.last set. A packet needing more than MAX_FRAGS fragments
//    (or a nonzero length with frag_units zero) gives one result with last and too_many.
//  - The constant header words are first summed through the shared checksum adder, then each
//    fragment adds two words on that adder (length word, then flags/offset word).
//    An item occupies the block until its last result (also in the error case); busy drops
//    in the cycle that shows the last result, so the next start may be taken then.
//  - The receiver cannot stall: done/result are valid for exactly one cycle.
//  - Reset returns the sequencer to idle, clears done and sets frag_units to 64.
module ipv4_header_fragmenter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ihf_pkg::FRAG_UNITS_W-1:0] cfg_wr_data,
	input  logic                            start,
	input  ihf_pkg::hdr_t                   in_hdr,
	output logic                            busy,
	output logic                            done,
	output ihf_pkg::frag_t                  result
);
	import ihf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BASE,
		ST_LEN,
		ST_OFF
	} state_t;

	localparam frag_t ERR_RESULT = '{last: 1'b1, too_many: 1'b1, default: '0};

	state_t                  state_q;
	logic [FRAG_UNITS_W-1:0] frag_units_q;
	hdr_t                    hdr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [15:0]             remain_q;
	logic [FRAG_UNITS_W-1:0] off_q;
	logic [15:0]             len_q;
	logic                    last_q;

	logic [15:0]             fsize;
	logic                    is_last;
	logic [15:0]             len_next;
	logic [15:0]             fo_word;
	logic [15:0]             base_word;
	logic [LIMIT_W-1:0]      limit;
	logic                    too_many;
	logic                    accept;
	csum_ctrl_t              cs_ctrl;
	logic [15:0]             cs_sum;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign fsize    = {frag_units_q, 3'b000};
	assign is_last  = (remain_q <= fsize);
	assign len_next = is_last ? remain_q : fsize;
	assign fo_word  = {2'b00, ~last_q, off_q};
	assign limit    = LIMIT_W'(frag_units_q) * LIMIT_W'(LIMIT_MULT);
	// more than MAX_FRAGS fragments exactly when the length exceeds MAX_FRAGS full ones
	assign too_many = (LIMIT_W'(hdr_q.total_len) > limit);

	always_comb begin
		case (cnt_q)
			3'd0:    base_word = {hdr_q.tos, hdr_q.ver_ihl};
			3'd1:    base_word = hdr_q.ident;
			3'd2:    base_word = {hdr_q.protocol, hdr_q.ttl};
			3'd3:    base_word = hdr_q.src_addr[15:0];
			3'd4:    base_word = hdr_q.src_addr[31:16];
			3'd5:    base_word = hdr_q.dst_addr[15:0];
			3'd6:    base_word = hdr_q.dst_addr[31:16];
			default: base_word = '0;
		endcase
	end

	always_comb begin
		cs_ctrl.op   = CS_HOLD;
		cs_ctrl.word = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cs_ctrl.op = CS_CLEAR;
				end
			end
			ST_BASE: begin
				cs_ctrl.op   = CS_BASE;
				cs_ctrl.word = base_word;
			end
			ST_LEN: begin
				cs_ctrl.op   = CS_FROM_BASE;
				cs_ctrl.word = len_next;
			end
			ST_OFF: begin
				cs_ctrl.op   = CS_ACC;
				cs_ctrl.word = fo_word;
			end
			default: ;
		endcase
	end

	ihf_csum_unit u_csum (
		.clk  (clk),
		.ctrl (cs_ctrl),
		.sum  (cs_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_units_q <= FRAG_UNITS_RESET;
		end else if (cfg_wr_en) begin
			frag_units_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done     <= 1'b0;
			result   <= '0;
			hdr_q    <= '0;
			cnt_q    <= '0;
			remain_q <= '0;
			off_q    <= '0;
			len_q    <= '0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done <= 1'b0;
					if (accept) begin
						hdr_q    <= in_hdr;
						remain_q <= in_hdr.total_len;
						off_q    <= '0;
						cnt_q    <= '0;
						state_q  <= ST_BASE;
					end
				end
				ST_BASE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					done  <= (cnt_q == CNT_W'(BASE_WORDS - 1)) && too_many;
					if (cnt_q == CNT_W'(BASE_WORDS - 1)) begin
						if (too_many) begin
							result  <= ERR_RESULT;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_LEN;
						end
					end
				end
				ST_LEN: begin
					done    <= 1'b0;
					len_q   <= len_next;
					last_q  <= is_last;
					state_q <= ST_OFF;
				end
				ST_OFF: begin
					result.frag_ver_ihl    <= hdr_q.ver_ihl;
					result.frag_tos        <= hdr_q.tos;
					result.frag_len        <= len_q;
					result.frag_ident      <= hdr_q.ident;
					result.flags_offset    <= fo_word;
					result.frag_ttl        <= hdr_q.ttl;
					result.frag_protocol   <= hdr_q.protocol;
					result.header_checksum <= ~cs_sum;
					result.frag_src        <= hdr_q.src_addr;
					result.frag_dst        <= hdr_q.dst_addr;
					result.last            <= last_q;
					result.too_many        <= 1'b0;
					done                   <= 1'b1;
					remain_q               <= remain_q - fsize;
					off_q                  <= off_q + frag_units_q;
					state_q                <= last_q ? ST_IDLE : ST_LEN;
				end
				default: begin
					done    <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/ihf_csum_unit.sv
// Shared ones' complement adder with the per-packet base sum and the per-fragment sum.
module ihf_csum_unit (
	input  logic              clk,
	input  ihf_pkg::csum_ctrl_t ctrl,
	output logic [15:0]       sum
);
	import ihf_pkg::*;

	logic [15:0] base_q;
	logic [15:0] acc_q;
	logic [15:0] op_a;
	logic [16:0] raw;

	always_comb begin
		case (ctrl.op)
			CS_ACC:  op_a = acc_q;
			default: op_a = base_q;
		endcase
		raw = {1'b0, op_a} + {1'b0, ctrl.word};
		// end-around carry; cannot overflow again
		sum = raw[15:0] + {15'd0, raw[16]};
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CS_CLEAR:     base_q <= '0;
			CS_BASE:      base_q <= sum;
			CS_FROM_BASE: acc_q <= sum;
			CS_ACC:       acc_q <= sum;
			default: ;
		endcase
	end

endmodule

// File: rtl/ihf_checker.sv
// Port-level assertions for the IPv4 header fragmenter, bound to the top level.
module ihf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input ihf_pkg::frag_t                  result
);
	import ihf_pkg::*;

	// an accepted header occupies the block in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// more results follow a result that is not the last
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |=> busy && !done)
		else $error("sequence ended without a last result");

	// the last result frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |-> !busy)
		else $error("block still busy after last result");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.too_many |-> result.last && result.header_checksum == 16'h0000)
		else $error("error result malformed");

	a_mf_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.too_many |-> result.flags_offset[MF_BIT] == !result.last)
		else $error("more-fragments flag disagrees with last");

endmodule

bind ipv4_header_fragmenter_unit ihf_checker u_ihf_checker (.*);

// File: tb/ipv4_header_fragmenter_unit_tb.sv
// Self-checking testbench for the IPv4 header fragmenter: directed table, then random phases.
`timescale 1ns / 1ps

module ipv4_header_fragmenter_unit_tb;
	import ihf_pkg::*;

	typedef enum logic [1:0] {
		FILL_ZERO,
		FILL_ONES,
		FILL_RAND
	} fill_t;

	typedef struct {
		int unsigned units;
		int unsigned tlen;
		fill_t       fill;
		bit          rejected;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [FRAG_UNITS_W-1:0] cfg_wr_data;
	logic                    start;
	hdr_t                    in_hdr;
	logic                    busy;
	logic                    done;
	frag_t                   result;

	frag_t                   pending_frags[$];
	stim_row_t               stim_table[$];
	int unsigned             frag_units_cfg;
	int unsigned             mismatches;

	ipv4_header_fragmenter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.in_hdr     (in_hdr),
		.busy       (busy),
		.done       (done),
		.result     (result)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] hdr_csum(input frag_t f);
		logic [31:0] s;
		s = {f.frag_tos, f.frag_ver_ihl} + f.frag_len + f.frag_ident + f.flags_offset
			+ {f.frag_protocol, f.frag_ttl} + f.frag_src[15:0] + f.frag_src[31:16]
			+ f.frag_dst[15:0] + f.frag_dst[31:16];
		while (s[31:16] != 16'd0)
			s = s[15:0] + s[31:16];
		return ~s[15:0];
	endfunction

	// Queues every fragment header that one accepted packet header should produce.
	task automatic fragment_header(input hdr_t h);
		int unsigned fsize;
		int unsigned full;
		int unsigned n;
		int unsigned rem;
		int unsigned i;
		frag_t       f;
		fsize = frag_units_cfg * 8;
		full = 0;
		if (h.total_len != 16'd0)
			full = (fsize == 0) ? MAX_FRAGS : (h.total_len - 1) / fsize;
		n = full + 1;
		f = '0;
		if (n > MAX_FRAGS) begin
			f.last = 1'b1;
			f.too_many = 1'b1;
			pending_frags.push_back(f);
			return;
		end
		rem = h.total_len - full * fsize;
		for (i = 0; i < n; i++) begin
			f.frag_ver_ihl  = h.ver_ihl;
			f.frag_tos      = h.tos;
			f.frag_len      = 16'((i == n - 1) ? rem : fsize);
			f.frag_ident    = h.ident;
			f.flags_offset  = {2'b00, i != n - 1, 13'(i * frag_units_cfg)};
			f.frag_ttl      = h.ttl;
			f.frag_protocol = h.protocol;
			f.frag_src      = h.src_addr;
			f.frag_dst      = h.dst_addr;
			f.last          = (i == n - 1);
			f.too_many      = 1'b0;
			f.header_checksum = 16'd0;
			f.header_checksum = hdr_csum(f);
			pending_frags.push_back(f);
		end
	endtask

	function automatic hdr_t random_hdr();
		return {$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	// Lengths near fragment boundaries up to one past the limit, or any length.
	function automatic int unsigned pick_len(input int unsigned units);
		int unsigned fsize;
		int unsigned k;
		int          len;
		fsize = units * 8;
		k = $urandom_range(1, MAX_FRAGS);
		case ($urandom_range(0, 9))
			0: len = $urandom_range(0, 65535);
			1: len = 0;
			2, 3: len = k * fsize + $urandom_range(0, 2) - 1;
			default: begin
				len = (k * fsize > 65535) ? 65535 : k * fsize;
				len = $urandom_range(1, (len < 1) ? 1 : len);
			end
		endcase
		if (len < 0)
			len = 0;
		if (len > 65535)
			len = 65535;
		return len;
	endfunction

	task automatic send_hdr(input hdr_t h, input bit typed_reject);
		frag_t rej;
		start <= 1'b1;
		in_hdr <= h;
		do @(posedge clk); while (busy);
		if (typed_reject) begin
			rej = '0;
			rej.last = 1'b1;
			rej.too_many = 1'b1;
			pending_frags.push_back(rej);
		end else begin
			fragment_header(h);
		end
	endtask

	task automatic idle_gap(input bit allow);
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	// Register writes only once the block has drained.
	task automatic set_units(input int unsigned units);
		start <= 1'b0;
		while (pending_frags.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= FRAG_UNITS_W'(units);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		frag_units_cfg = units;
	endtask

	task automatic add_row(input int unsigned units, input int unsigned tlen,
		input fill_t fill, input bit rejected);
		stim_row_t r;
		r.units = units;
		r.tlen = tlen;
		r.fill = fill;
		r.rejected = rejected;
		stim_table.push_back(r);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		frag_t want;
		if (done) begin
			if (pending_frags.size() == 0) begin
				$error("fragment header transfer with nothing expected");
				mismatches++;
			end else begin
				want = pending_frags.pop_front();
				cmp_field("frag_ver_ihl", want.frag_ver_ihl, result.frag_ver_ihl);
				cmp_field("frag_tos", want.frag_tos, result.frag_tos);
				cmp_field("frag_len", want.frag_len, result.frag_len);
				cmp_field("frag_ident", want.frag_ident, result.frag_ident);
				cmp_field("flags_offset", want.flags_offset, result.flags_offset);
				cmp_field("frag_ttl", want.frag_ttl, result.frag_ttl);
				cmp_field("frag_protocol", want.frag_protocol, result.frag_protocol);
				cmp_field("header_checksum", want.header_checksum, result.header_checksum);
				cmp_field("frag_src", want.frag_src, result.frag_src);
				cmp_field("frag_dst", want.frag_dst, result.frag_dst);
				cmp_field("last", want.last, result.last);
				cmp_field("too_many", want.too_many, result.too_many);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned phase_units[8];
		hdr_t        h;
		int unsigned p;
		int unsigned j;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		in_hdr = '0;
		mismatches = 0;
		frag_units_cfg = FRAG_UNITS_RESET;

		// rows on the reset value first, then the extremes of the register
		add_row(64, 0, FILL_ZERO, 1'b0);
		add_row(64, 20, FILL_ZERO, 1'b0);
		add_row(64, 65535, FILL_ONES, 1'b1);
		add_row(64, 16384, FILL_RAND, 1'b0);
		add_row(64, 16385, FILL_RAND, 1'b1);
		add_row(64, 512, FILL_RAND, 1'b0);
		add_row(64, 513, FILL_ONES, 1'b0);
		add_row(1, 8, FILL_RAND, 1'b0);
		add_row(1, 256, FILL_RAND, 1'b0);
		add_row(1, 257, FILL_ONES, 1'b1);
		add_row(1, 0, FILL_ONES, 1'b0);
		add_row(8191, 65535, FILL_ONES, 1'b0);
		add_row(8191, 65528, FILL_RAND, 1'b0);
		add_row(8191, 1, FILL_ZERO, 1'b0);
		add_row(0, 0, FILL_RAND, 1'b0);
		add_row(0, 1, FILL_ZERO, 1'b1);
		add_row(0, 65535, FILL_ONES, 1'b1);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].units != frag_units_cfg)
				set_units(stim_table[i].units);
			case (stim_table[i].fill)
				FILL_ZERO: h = '0;
				FILL_ONES: h = '1;
				default:   h = random_hdr();
			endcase
			h.total_len = 16'(stim_table[i].tlen);
			idle_gap(1'b1);
			send_hdr(h, stim_table[i].rejected);
		end

		phase_units = '{1, 8191, 0, 64, 0, 0, 2, 0};
		for (p = 0; p < 8; p++) begin
			if (phase_units[p] == 0 && p != 2)
				phase_units[p] = $urandom_range(1, 8191 >> $urandom_range(0, 12));
			set_units(phase_units[p]);
			for (j = 0; j < 45; j++) begin
				h = random_hdr();
				h.total_len = 16'(pick_len(frag_units_cfg));
				// phase 3 runs back to back with no idle cycles
				idle_gap(p != 3);
				send_hdr(h, 1'b0);
			end
		end

		start <= 1'b0;
		while (pending_frags.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: ipv4_header_fragmenter_unit.f
rtl/ihf_pkg.sv
rtl/ihf_csum_unit.sv
rtl/ipv4_header_fragmenter_unit.sv
rtl/ihf_checker.sv
tb/ipv4_header_fragmenter_unit_tb.sv
